/* hdl/process_record_sorter_core_defines.svh */
// assertion macros for the process record sorter
`ifndef PROCESS_RECORD_SORTER_CORE_DEFINES_SVH
`define PROCESS_RECORD_SORTER_CORE_DEFINES_SVH
`ifndef SYNTH
`define PRS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define PRS_ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define PRS_ASSERT(label, clk, rst, prop, msg)
`define PRS_ASSERT_NEVER(label, clk, rst, expr, msg)
`endif
`endif

/* hdl/prs_pkg.sv */
package prs_pkg;

   // input transfer payload
   typedef struct packed {
      logic [21:0] proc_id;
      logic [21:0] parent_id;
      logic [35:0] resident_kb;
      logic [22:0] cpu_share;
      logic [7:0]  run_state;
      logic        batch_last;
   } req_type;

   // result transfer payload
   typedef struct packed {
      logic [21:0] out_proc_id;
      logic [21:0] out_parent_id;
      logic [35:0] out_resident_kb;
      logic [22:0] out_cpu_share;
      logic [7:0]  out_run_state;
      logic        out_last;
   } rsp_type;

   // one stored record
   typedef struct packed {
      logic [21:0] proc_id;
      logic [21:0] parent_id;
      logic [35:0] resident_kb;
      logic [22:0] cpu_share;
      logic [7:0]  run_state;
   } rec_type;

   typedef logic [1:0] mode_type;

   // sort key codes
   localparam mode_type MODE_CPU = 2'd0;
   localparam mode_type MODE_MEM = 2'd1;
   localparam mode_type MODE_PID = 2'd2;

   // register indexes and data width
   localparam int CSR_W = 7;
   localparam logic CSR_SORT_MODE  = 1'b0;
   localparam logic CSR_SHOW_LIMIT = 1'b1;

   // controls broadcast along the cell row
   typedef struct packed {
      logic append;
      logic sort_en;
      logic parity;
      logic shift;
      logic clear;
   } cell_ctl_type;

   // true when the earlier record a must move behind the later record b
   function automatic logic goes_after(mode_type mode, rec_type a, rec_type b);
      logic res;
      case (mode)
         MODE_MEM: res = (a.resident_kb < b.resident_kb);
         MODE_PID: res = (a.proc_id > b.proc_id);
         default:  res = (a.cpu_share < b.cpu_share);
      endcase
      return res;
   endfunction

endpackage

/* hdl/prs_cell.sv */
module prs_cell #(
   parameter int IDX = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  prs_pkg::cell_ctl_type ctl,
   input  prs_pkg::mode_type     mode,
   input  prs_pkg::rec_type      new_rec,
   input  prs_pkg::rec_type      lower_rec,
   input  logic                  lower_valid,
   input  logic                  lower_swap,
   input  prs_pkg::rec_type      upper_rec,
   input  logic                  upper_valid,
   output prs_pkg::rec_type      rec,
   output logic                  valid,
   output logic                  swap_up
);

   localparam logic PAR = 1'(IDX % 2);

   prs_pkg::rec_type rec_ff, rec_in;
   logic             valid_ff, valid_in;

   // compare-exchange with the upper neighbour on this cell's phase
   assign swap_up = ctl.sort_en && (ctl.parity == PAR) && valid_ff && upper_valid &&
                    prs_pkg::goes_after(mode, rec_ff, upper_rec);

   // next contents: clear, append, shift down, or exchange
   always_comb begin
      rec_in   = rec_ff;
      valid_in = valid_ff;
      if (ctl.clear) begin
         valid_in = 1'b0;
      end else if (ctl.append) begin
         if (!valid_ff && lower_valid) begin
            rec_in   = new_rec;
            valid_in = 1'b1;
         end
      end else if (ctl.shift) begin
         rec_in   = upper_rec;
         valid_in = upper_valid;
      end else if (swap_up) begin
         rec_in = upper_rec;
      end else if (lower_swap) begin
         rec_in = lower_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

   assign rec   = rec_ff;
   assign valid = valid_ff;

endmodule

/* hdl/process_record_sorter_core.sv */
// records are stored one per cycle at the end of a row of CAPACITY cells, in arrival order
// after the batch's last record input stalls and the row runs odd-even exchange sorting
// results then leave one per cycle, unless stalled, from cell 0 through an output register
// reset is synchronous and active high: clears the store, the state and both registers
`include "process_record_sorter_core_defines.svh"

module process_record_sorter_core #(
   parameter int CAPACITY = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  prs_pkg::req_type         req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output prs_pkg::rsp_type         rsp_data,
   input  logic                     csr_we,
   input  logic                     csr_index,
   input  logic [prs_pkg::CSR_W-1:0] csr_wdata
);

   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int PW   = $clog2(CAPACITY);
   localparam int CMPW = (CW > prs_pkg::CSR_W) ? CW : prs_pkg::CSR_W;

   localparam logic [1:0] ST_FILL = 2'd0;
   localparam logic [1:0] ST_SORT = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0]             state_ff, state_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [CW-1:0]          emit_num_ff, emit_num_in;
   logic [CW-1:0]          sent_ff, sent_in;
   logic [PW-1:0]          phase_ff, phase_in;
   prs_pkg::mode_type      sort_mode_ff;
   logic [prs_pkg::CSR_W-1:0] show_limit_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   prs_pkg::rsp_type       rsp_data_ff, rsp_data_in;

   logic                   req_accept, rsp_load, rsp_last, full;
   logic [CW-1:0]          batch_count;
   prs_pkg::cell_ctl_type  ctl;
   prs_pkg::rec_type       new_rec;
   prs_pkg::rec_type       cell_rec [CAPACITY];
   logic [CAPACITY-1:0]    valid_vec;
   logic [CAPACITY-1:0]    swap_vec;

   // handshake
   assign req_stall  = (state_ff != ST_FILL);
   assign req_accept = req_valid && !req_stall;
   assign rsp_load   = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);
   assign rsp_last   = ((sent_ff + CW'(1)) == emit_num_ff);
   assign full       = (count_ff == CW'(CAPACITY));
   assign batch_count = full ? count_ff : (count_ff + CW'(1));

   assign new_rec.proc_id     = req_data.proc_id;
   assign new_rec.parent_id   = req_data.parent_id;
   assign new_rec.resident_kb = req_data.resident_kb;
   assign new_rec.cpu_share   = req_data.cpu_share;
   assign new_rec.run_state   = req_data.run_state;

   // row controls
   assign ctl.append  = req_accept;
   assign ctl.sort_en = (state_ff == ST_SORT);
   assign ctl.parity  = phase_ff[0];
   assign ctl.shift   = rsp_load;
   assign ctl.clear   = rsp_load && rsp_last;

   // cell row
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      prs_pkg::rec_type lower_rec, upper_rec;
      logic             lower_valid, lower_swap, upper_valid;
      if (i == 0) begin : g_head
         assign lower_rec   = '0;
         assign lower_valid = 1'b1;
         assign lower_swap  = 1'b0;
      end else begin : g_mid_low
         assign lower_rec   = cell_rec[i-1];
         assign lower_valid = valid_vec[i-1];
         assign lower_swap  = swap_vec[i-1];
      end
      if (i == CAPACITY - 1) begin : g_tail
         assign upper_rec   = '0;
         assign upper_valid = 1'b0;
      end else begin : g_mid_up
         assign upper_rec   = cell_rec[i+1];
         assign upper_valid = valid_vec[i+1];
      end
      prs_cell #(
         .IDX(i)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .mode        (sort_mode_ff),
         .new_rec     (new_rec),
         .lower_rec   (lower_rec),
         .lower_valid (lower_valid),
         .lower_swap  (lower_swap),
         .upper_rec   (upper_rec),
         .upper_valid (upper_valid),
         .rec         (cell_rec[i]),
         .valid       (valid_vec[i]),
         .swap_up     (swap_vec[i])
      );
   end

   // batch sequencer
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      emit_num_in = emit_num_ff;
      sent_in     = sent_ff;
      phase_in    = phase_ff;
      unique case (state_ff)
         ST_FILL: begin
            if (req_accept) begin
               count_in = batch_count;
               if (req_data.batch_last) begin
                  if ((show_limit_ff != '0) &&
                      (CMPW'(show_limit_ff) < CMPW'(batch_count))) begin
                     emit_num_in = CW'(show_limit_ff);
                  end else begin
                     emit_num_in = batch_count;
                  end
                  phase_in = '0;
                  sent_in  = '0;
                  state_in = ST_SORT;
               end
            end
         end
         ST_SORT: begin
            phase_in = phase_ff + PW'(1);
            if (phase_ff == PW'(CAPACITY - 1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_load) begin
               sent_in = sent_ff + CW'(1);
               if (rsp_last) begin
                  count_in = '0;
                  state_in = ST_FILL;
               end
            end
         end
         default: begin
            state_in = ST_FILL;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in                = 1'b1;
         rsp_data_in.out_proc_id     = cell_rec[0].proc_id;
         rsp_data_in.out_parent_id   = cell_rec[0].parent_id;
         rsp_data_in.out_resident_kb = cell_rec[0].resident_kb;
         rsp_data_in.out_cpu_share   = cell_rec[0].cpu_share;
         rsp_data_in.out_run_state   = cell_rec[0].run_state;
         rsp_data_in.out_last        = rsp_last;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL;
         count_ff     <= '0;
         emit_num_ff  <= '0;
         sent_ff      <= '0;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         emit_num_ff  <= emit_num_in;
         sent_ff      <= sent_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sort_mode_ff  <= prs_pkg::MODE_CPU;
         show_limit_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            prs_pkg::CSR_SORT_MODE:  sort_mode_ff  <= csr_wdata[1:0];
            prs_pkg::CSR_SHOW_LIMIT: show_limit_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checks
   `PRS_ASSERT(a_count_range, clock, reset, count_ff <= CW'(CAPACITY), "stored count above capacity")
   `PRS_ASSERT(a_valid_count, clock, reset, (state_ff != ST_EMIT) |-> ($countones(valid_vec) == int'(count_ff)), "valid cells do not match stored count")
   `PRS_ASSERT(a_batch_end, clock, reset, (rsp_load && rsp_last) |=> (state_ff == ST_FILL && count_ff == '0 && valid_vec == '0), "store not emptied after final transfer")

endmodule
